[sv/aesctr_pkg.sv]
package aesctr_pkg;

  localparam int BLOCK_BYTES   = 16;
  localparam int CIPHER_ROUNDS = 10;
  localparam int BLOCK_W       = 8 * BLOCK_BYTES;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int OFFSET_W      = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_OFFSET = 3'd4;

  // one pipeline slot handed from cell to cell
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [BLOCK_W-1:0] data;
    logic [BLOCK_W-1:0] state;
    logic [BLOCK_W-1:0] rkey;
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [CIPHER_ROUNDS] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte n of a block sits in the top bits, byte 0 highest
  function automatic logic [7:0] get_byte(input logic [BLOCK_W-1:0] s, input int n);
    get_byte = s[BLOCK_W-1-8*n -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // sub bytes and shift rows together
  function automatic logic [BLOCK_W-1:0] sub_shift(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BLOCK_W-1-8*(r+4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
      end
    end
    sub_shift = t;
  endfunction

  function automatic logic [BLOCK_W-1:0] mix_columns(input logic [BLOCK_W-1:0] s);
    logic [BLOCK_W-1:0] t;
    logic [7:0] a0, a1, a2, a3, all;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0  = get_byte(s, 4*c);
      a1  = get_byte(s, 4*c + 1);
      a2  = get_byte(s, 4*c + 2);
      a3  = get_byte(s, 4*c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      t[BLOCK_W-1-8*(4*c) -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                                    a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
    end
    mix_columns = t;
  endfunction

  // one step of the key schedule: four words of round key to the next four
  function automatic logic [BLOCK_W-1:0] key_step(input logic [BLOCK_W-1:0] rk,
                                                  input logic [7:0] rc);
    logic [31:0] t, w4, w5, w6, w7;
    t  = {SBOX[rk[23:16]], SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]} ^ {rc, 24'h0};
    w4 = rk[127:96] ^ t;
    w5 = rk[95:64] ^ w4;
    w6 = rk[63:32] ^ w5;
    w7 = rk[31:0] ^ w6;
    key_step = {w4, w5, w6, w7};
  endfunction

endpackage

[sv/aesctr_cell.sv]
module aesctr_cell import aesctr_pkg::*; #(
  parameter int ROUND = 1
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  stage_t prev,
  output stage_t cur
);

  localparam bit FINAL = (ROUND == CIPHER_ROUNDS);

  stage_t             cur_r;
  logic [BLOCK_W-1:0] rk_nxt;
  logic [BLOCK_W-1:0] ss;
  logic [BLOCK_W-1:0] st_nxt;

  // round key for this round, derived from the one handed in
  assign rk_nxt = key_step(prev.rkey, RCON[ROUND-1]);

  // one cipher round, no column mix in the final round
  always_comb begin
    ss = sub_shift(prev.state);
    if (FINAL) begin
      st_nxt = ss ^ rk_nxt;
    end else begin
      st_nxt = mix_columns(ss) ^ rk_nxt;
    end
  end

  // slot register, moves whenever the chain moves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.valid <= 1'b0;
    end else if (en) begin
      cur_r.valid <= prev.valid;
    end
    if (en) begin
      cur_r.last  <= prev.last;
      cur_r.data  <= prev.data;
      cur_r.state <= st_nxt;
      cur_r.rkey  <= rk_nxt;
    end
  end

  assign cur = cur_r;

endmodule

[sv/aes128_ctr_block_xcrypt.sv]
// AES-128 counter-mode engine. Each input word is a 16-byte block (in_tdata bits 63:0 hold
// bytes 0..7, bits 127:64 bytes 8..15, byte 0 / byte 8 in the top bits of each half); the
// result is that block XORed with the AES-128 encryption of a 128-bit counter, which then
// steps by one and wraps at 2^128. tlast is carried through unchanged. The cipher is a
// chain of ten round cells, each also computing its own round key from the previous one,
// so a block enters every cycle unless the output word is held, which alone stalls the
// chain. Any write to a register index 0..4 reloads the counter
// with {iv_high, iv_low} + block_offset; write registers only while idle.
module aes128_ctr_block_xcrypt import aesctr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BLOCK_W-1:0]    in_tdata,   // data_high [63:0], data_low [127:64]
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [BLOCK_W-1:0]    out_tdata,  // result_high [63:0], result_low [127:64]
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [63:0]         key_hi_r, key_hi_nxt, key_lo_r, key_lo_nxt;
  logic [63:0]         iv_hi_r, iv_hi_nxt, iv_lo_r, iv_lo_nxt;
  logic [OFFSET_W-1:0] off_r, off_nxt;
  logic                cfg_hit;
  logic [64:0]         start_lo;
  logic [BLOCK_W-1:0]  start_cnt;
  logic [BLOCK_W-1:0]  cnt_r, cnt_nxt;
  logic                en;
  logic                in_acc;
  stage_t              chain [CIPHER_ROUNDS+1];
  stage_t              s0_r;
  logic [BLOCK_W-1:0]  ks_out;

  // register decode
  always_comb begin
    key_hi_nxt = key_hi_r;
    key_lo_nxt = key_lo_r;
    iv_hi_nxt  = iv_hi_r;
    iv_lo_nxt  = iv_lo_r;
    off_nxt    = off_r;
    cfg_hit    = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_HIGH: begin
          key_hi_nxt = cfg_wdata;
          cfg_hit    = 1'b1;
        end
        REG_KEY_LOW: begin
          key_lo_nxt = cfg_wdata;
          cfg_hit    = 1'b1;
        end
        REG_IV_HIGH: begin
          iv_hi_nxt = cfg_wdata;
          cfg_hit   = 1'b1;
        end
        REG_IV_LOW: begin
          iv_lo_nxt = cfg_wdata;
          cfg_hit   = 1'b1;
        end
        REG_BLOCK_OFFSET: begin
          off_nxt = cfg_wdata[OFFSET_W-1:0];
          cfg_hit = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  // start counter: low half add, carry into the high half
  assign start_lo  = {1'b0, iv_lo_nxt} + {33'h0, off_nxt};
  assign start_cnt = {iv_hi_nxt + {63'h0, start_lo[64]}, start_lo[63:0]};

  // chain moves unless the output word is held
  assign en        = !(chain[CIPHER_ROUNDS].valid && !out_tready);
  assign in_tready = en;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (cfg_hit) begin
      cnt_nxt = start_cnt;
    end else if (in_acc) begin
      cnt_nxt = cnt_r + 128'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      iv_hi_r  <= '0;
      iv_lo_r  <= '0;
      off_r    <= '0;
      cnt_r    <= '0;
    end else begin
      key_hi_r <= key_hi_nxt;
      key_lo_r <= key_lo_nxt;
      iv_hi_r  <= iv_hi_nxt;
      iv_lo_r  <= iv_lo_nxt;
      off_r    <= off_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry slot: initial key whitening of the counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
    end else if (en) begin
      s0_r.valid <= in_tvalid;
    end
    if (en) begin
      s0_r.last  <= in_tlast;
      s0_r.data  <= {in_tdata[63:0], in_tdata[127:64]};
      s0_r.state <= cnt_r ^ {key_hi_r, key_lo_r};
      s0_r.rkey  <= {key_hi_r, key_lo_r};
    end
  end

  assign chain[0] = s0_r;

  // round cells
  for (genvar g = 1; g <= CIPHER_ROUNDS; g++) begin : g_round
    aesctr_cell #(.ROUND(g)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .prev (chain[g-1]),
      .cur  (chain[g])
    );
  end

  // keystream xor on the way out
  assign ks_out     = chain[CIPHER_ROUNDS].data ^ chain[CIPHER_ROUNDS].state;
  assign out_tvalid = chain[CIPHER_ROUNDS].valid;
  assign out_tdata  = {ks_out[63:0], ks_out[127:64]};
  assign out_tlast  = chain[CIPHER_ROUNDS].last;

  // counter steps by one for each word taken when no register is written
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_hit) |=> (cnt_r == $past(cnt_r) + 128'd1))
    else $error("counter did not step");

  // register write reloads the counter from the new iv and offset
  a_cnt_load: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (cnt_r == {iv_hi_r, iv_lo_r} + {96'h0, off_r}))
    else $error("counter not reloaded");

  // a word accepted enters the chain
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> chain[0].valid)
    else $error("accepted word lost");

  // stalled output keeps the entry slot in place
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(s0_r.valid))
    else $error("chain moved while stalled");

endmodule

[verif/aes128_ctr_block_xcrypt_tb.sv]
`timescale 1ns / 1ps
module aes128_ctr_block_xcrypt_tb;
  import aesctr_pkg::*;

  // keystream predictor: own copy of registers, counter and round keys
  class ctr_scoreboard;
    logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
    logic [31:0] offset;
    logic [127:0] counter;
    logic [31:0] rk [44];
    logic [128:0] pending [$];
    int errors;
    int shown;

    function new();
      key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0; offset = '0;
      errors = 0; shown = 0;
      reload();
    endfunction

    function logic [7:0] sb(input logic [7:0] b);
      logic [7:0] tab [256];
      tab = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return tab[b];
    endfunction

    function logic [7:0] dbl(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // key schedule and counter reload, done on every write to a register index 0..4
    function void reload();
      logic [31:0] t;
      logic [7:0] rc;
      rk[0] = key_hi[63:32]; rk[1] = key_hi[31:0];
      rk[2] = key_lo[63:32]; rk[3] = key_lo[31:0];
      rc = 8'h01;
      for (int i = 4; i < 44; i++) begin
        t = rk[i-1];
        if (i % 4 == 0) begin
          t = {sb(t[23:16]), sb(t[15:8]), sb(t[7:0]), sb(t[31:24])} ^ {rc, 24'h0};
          rc = dbl(rc);
        end
        rk[i] = rk[i-4] ^ t;
      end
      counter = {iv_hi, iv_lo} + {96'h0, offset};
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
      case (idx)
        REG_KEY_HIGH:     key_hi = v;
        REG_KEY_LOW:      key_lo = v;
        REG_IV_HIGH:      iv_hi = v;
        REG_IV_LOW:       iv_lo = v;
        REG_BLOCK_OFFSET: offset = v[31:0];
        default:          return;
      endcase
      reload();
    endfunction

    // byte n of the state, byte 0 in the top bits
    function logic [127:0] cipher(input logic [127:0] blk);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, x;
      logic [127:0] r;
      for (int n = 0; n < 16; n++) s[n] = blk[127-8*n -: 8];
      for (int rnd = 0; rnd <= 10; rnd++) begin
        if (rnd > 0) begin
          for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++) t[w+4*c] = sb(s[w + 4*((c+w)%4)]);
          s = t;
          if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
              a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
              x = a0 ^ a1 ^ a2 ^ a3;
              s[4*c]   = a0 ^ x ^ dbl(a0 ^ a1);
              s[4*c+1] = a1 ^ x ^ dbl(a1 ^ a2);
              s[4*c+2] = a2 ^ x ^ dbl(a2 ^ a3);
              s[4*c+3] = a3 ^ x ^ dbl(a3 ^ a0);
            end
          end
        end
        for (int c = 0; c < 4; c++)
          for (int w = 0; w < 4; w++) s[4*c+w] ^= rk[4*rnd+c][31-8*w -: 8];
      end
      for (int n = 0; n < 16; n++) r[127-8*n -: 8] = s[n];
      return r;
    endfunction

    // expected word: {last, low half, high half} in port order
    function void note_input(input logic [127:0] data, input logic last);
      logic [127:0] ks;
      ks = cipher(counter);
      pending.push_back({last, data[127:64] ^ ks[63:0], data[63:0] ^ ks[127:64]});
      counter = counter + 128'd1;
    endfunction

    function void check_result(input logic [127:0] data, input logic last);
      logic [128:0] e;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result word %h last %b", data, last);
        end
        return;
      end
      e = pending.pop_front();
      if (e[127:0] !== data || e[128] !== last) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: expected %h last %b, got %h last %b",
                   e[127:0], e[128], data, last);
        end
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [BLOCK_W-1:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [BLOCK_W-1:0] out_tdata;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ctr_scoreboard sb_ctr;
  int cycles;
  int hold_off;
  bit sink_rand;

  aes128_ctr_block_xcrypt i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    hold_off = 0;
    sink_rand = 1'b1;
    sb_ctr = new();
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb_ctr.check_result(out_tdata, out_tlast);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= sink_rand ? (gap_len() == 0) : 1'b1;
      end
    end
  end

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end
  initial cycles = 0;

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    sb_ctr.write_reg(idx, v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // valid stays up between back-to-back words and drops only for a gap
  task automatic send_word(input logic [127:0] d, input logic last, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1; in_tdata <= d; in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    sb_ctr.note_input(d, last);
  endtask

  // idle wait: everything drained plus pipeline latency
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb_ctr.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic config_random(input int kind);
    logic [63:0] hi, lo;
    logic [31:0] off;
    case (kind)
      0: begin hi = '0; lo = '0; off = '0; end
      1: begin hi = '1; lo = '1; off = '1; end
      2: begin hi = rnd64(); lo = 64'hffff_ffff_ffff_fff0; off = 32'h20; end
      default: begin hi = rnd64(); lo = rnd64(); off = $urandom; end
    endcase
    write_reg(REG_KEY_HIGH, kind == 1 ? '1 : (kind == 0 ? '0 : rnd64()));
    write_reg(REG_KEY_LOW, kind == 1 ? '1 : (kind == 0 ? '0 : rnd64()));
    write_reg(REG_IV_HIGH, hi);
    write_reg(REG_IV_LOW, lo);
    write_reg(REG_BLOCK_OFFSET, {rnd64() & 64'hffff_ffff_0000_0000} | off);
  endtask

  initial begin
    logic [127:0] d;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, field extremes, out-of-range index
    send_word('0, 1'b0, 1'b0);
    send_word('1, 1'b1, 1'b0);
    send_word({64'h0, 64'hffff_ffff_ffff_ffff}, 1'b0, 1'b0);
    send_word({64'hffff_ffff_ffff_ffff, 64'h0}, 1'b1, 1'b0);
    drain();
    write_reg(3'd5, rnd64());
    write_reg(3'd7, '1);
    send_word({16{8'ha5}}, 1'b0, 1'b0);
    drain();
    // counter wrap at all ones
    config_random(1);
    for (int i = 0; i < 4; i++) send_word(rnd64() ^ {rnd64(), 64'h0}, i[0], 1'b0);
    drain();
    // low half carries into high half
    config_random(2);
    for (int i = 0; i < 4; i++) send_word({rnd64(), rnd64()}, i[0], 1'b1);
    drain();

    // long receiver hold-off while the sender keeps offering
    hold_off = 60;
    for (int i = 0; i < 40; i++) send_word({rnd64(), rnd64()}, $urandom_range(0, 1), 1'b0);
    drain();

    // random phases under several settings
    for (int ph = 0; ph < 8; ph++) begin
      config_random(ph == 0 ? 0 : (ph == 1 ? 1 : 3));
      sink_rand = (ph != 4);
      for (int i = 0; i < 200; i++) begin
        d = {rnd64(), rnd64()};
        if ($urandom_range(0, 19) == 0) d = $urandom_range(0, 1) ? '1 : '0;
        send_word(d, $urandom_range(0, 7) == 0, ph != 5);
      end
      drain();
    end

    repeat (30) @(posedge clk);
    if (sb_ctr.errors == 0 && sb_ctr.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
